[rtl/rxp_pkg.sv]
// Shared types, constants and helpers for the rotate and perspective pipeline.
// Used by rxp_trig, rxp_rotate, rxp_divide and the top level; depends on nothing.
package rxp_pkg;

  // Sine and cosine generator.
  localparam int CORDIC_STEPS = 30;
  localparam int CW           = 34;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [CW-1:0] ONE_Q30     = 34'sd1073741824;
  localparam logic signed [CW-1:0] NEG_ONE_Q30 = -34'sd1073741824;

  localparam logic [29:0] ATAN_UNITS [0:CORDIC_STEPS-1] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
    30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1
  };

  // Rotated coordinates and products.
  localparam int COORD_W = 34;
  localparam int PROD_W  = 66;
  localparam logic signed [PROD_W-1:0] RND_HALF  = 66'sd536870912;
  localparam logic signed [PROD_W-1:0] LIM_HI    = 66'sd8589934591;
  localparam logic signed [PROD_W-1:0] LIM_LO    = -66'sd8589934591;

  // Perspective limits in whole pixels.
  localparam logic [15:0] MIN_FOCAL = 16'd80;
  localparam int          MIN_DENOM = 40;

  typedef struct packed {
    logic signed [31:0] cos_v;
    logic signed [31:0] sin_v;
  } sincos_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  // Round two Q30 products to nearest, add or subtract, and clamp the sum.
  function automatic logic signed [COORD_W-1:0] rot_mix(
    input logic signed [PROD_W-1:0] a,
    input logic signed [PROD_W-1:0] b,
    input logic                     sub
  );
    logic signed [PROD_W-1:0] ra;
    logic signed [PROD_W-1:0] rb;
    logic signed [PROD_W-1:0] s;
    ra = (a + RND_HALF) >>> 30;
    rb = (b + RND_HALF) >>> 30;
    s  = sub ? (ra - rb) : (ra + rb);
    if (s > LIM_HI) begin
      s = LIM_HI;
    end else if (s < LIM_LO) begin
      s = LIM_LO;
    end
    return COORD_W'(s);
  endfunction

endpackage

[rtl/rxp_trig.sv]
// Pipelined CORDIC producing sine and cosine of three angles, one step per stage.
// Carries the point alongside; depends on rxp_pkg.
module rxp_trig #(
  parameter int ANGLE_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [15:0]      angle_x,
  input  logic [15:0]      angle_y,
  input  logic [15:0]      angle_z,
  input  rxp_pkg::point_t  in_point,
  output logic             out_valid,
  output rxp_pkg::point_t  out_point,
  output rxp_pkg::sincos_t trig_x,
  output rxp_pkg::sincos_t trig_y,
  output rxp_pkg::sincos_t trig_z
);

  localparam int NS = rxp_pkg::CORDIC_STEPS;
  localparam int CW = rxp_pkg::CW;

  logic [15:0] ang [0:2];

  logic signed [CW-1:0] x_r   [0:NS][0:2];
  logic signed [CW-1:0] y_r   [0:NS][0:2];
  logic signed [CW-1:0] z_r   [0:NS][0:2];
  logic                 neg_r [0:NS][0:2];
  rxp_pkg::point_t      pt_r  [0:NS];
  logic                 vld_r [0:NS];

  rxp_pkg::sincos_t trig_r [0:2];
  rxp_pkg::point_t  opt_r;
  logic             ovld_r;

  assign ang[0] = angle_x;
  assign ang[1] = angle_y;
  assign ang[2] = angle_z;

  // Entry stage: fold the angle into the right half plane and load the start vector.
  for (genvar l = 0; l < 3; l++) begin : g_prep
    logic [31:0]          aw;
    logic                 neg_nxt;
    logic signed [CW-1:0] z_nxt;

    always_comb begin
      aw      = (32'(ang[l]) & ((32'd1 << ANGLE_BITS) - 32'd1)) << (32 - ANGLE_BITS);
      neg_nxt = aw[31] ^ aw[30];
      z_nxt   = CW'($signed({aw[31] ^ neg_nxt, aw[30:0]}));
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[0][l]   <= rxp_pkg::CORDIC_GAIN;
        y_r[0][l]   <= '0;
        z_r[0][l]   <= z_nxt;
        neg_r[0][l] <= neg_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt_r[0] <= in_point;
    end
  end

  // One rotation step per stage, three lanes side by side.
  for (genvar s = 0; s < NS; s++) begin : g_step
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic signed [CW-1:0] x_nxt;
      logic signed [CW-1:0] y_nxt;
      logic signed [CW-1:0] z_nxt;
      logic signed [CW-1:0] at;

      always_comb begin
        at = CW'($signed({1'b0, rxp_pkg::ATAN_UNITS[s]}));
        if (!z_r[s][l][CW-1]) begin
          x_nxt = x_r[s][l] - (y_r[s][l] >>> s);
          y_nxt = y_r[s][l] + (x_r[s][l] >>> s);
          z_nxt = z_r[s][l] - at;
        end else begin
          x_nxt = x_r[s][l] + (y_r[s][l] >>> s);
          y_nxt = y_r[s][l] - (x_r[s][l] >>> s);
          z_nxt = z_r[s][l] + at;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          x_r[s+1][l]   <= x_nxt;
          y_r[s+1][l]   <= y_nxt;
          z_r[s+1][l]   <= z_nxt;
          neg_r[s+1][l] <= neg_r[s][l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (en) begin
        vld_r[s+1] <= vld_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pt_r[s+1] <= pt_r[s];
      end
    end
  end

  // Output stage: undo the half turn and clamp to plus or minus one.
  for (genvar l = 0; l < 3; l++) begin : g_out
    logic signed [CW-1:0] cn;
    logic signed [CW-1:0] sn;
    rxp_pkg::sincos_t     trig_nxt;

    always_comb begin
      cn = neg_r[NS][l] ? -x_r[NS][l] : x_r[NS][l];
      sn = neg_r[NS][l] ? -y_r[NS][l] : y_r[NS][l];
      if (cn > rxp_pkg::ONE_Q30) begin
        cn = rxp_pkg::ONE_Q30;
      end else if (cn < rxp_pkg::NEG_ONE_Q30) begin
        cn = rxp_pkg::NEG_ONE_Q30;
      end
      if (sn > rxp_pkg::ONE_Q30) begin
        sn = rxp_pkg::ONE_Q30;
      end else if (sn < rxp_pkg::NEG_ONE_Q30) begin
        sn = rxp_pkg::NEG_ONE_Q30;
      end
      trig_nxt.cos_v = 32'(cn);
      trig_nxt.sin_v = 32'(sn);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        trig_r[l] <= trig_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (en) begin
      ovld_r <= vld_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      opt_r <= pt_r[NS];
    end
  end

  assign out_valid = ovld_r;
  assign out_point = opt_r;
  assign trig_x    = trig_r[0];
  assign trig_y    = trig_r[1];
  assign trig_z    = trig_r[2];

endmodule

[rtl/rxp_rotate.sv]
// Three chained axis rotations: Y, then X, then Z, each as a multiply stage and a sum stage.
// Depends on rxp_pkg for the product rounding and clamping helper.
module rxp_rotate (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  rxp_pkg::point_t                    in_point,
  input  rxp_pkg::sincos_t                   trig_x,
  input  rxp_pkg::sincos_t                   trig_y,
  input  rxp_pkg::sincos_t                   trig_z,
  output logic                               out_valid,
  output logic signed [rxp_pkg::COORD_W-1:0] x3,
  output logic signed [rxp_pkg::COORD_W-1:0] y3,
  output logic signed [rxp_pkg::COORD_W-1:0] z2
);

  localparam int PW = rxp_pkg::PROD_W;
  localparam int CO = rxp_pkg::COORD_W;

  logic [5:0] vld_r;

  // Stage 1: products for the turn about Y.
  logic signed [PW-1:0] a1_r, a2_r, a3_r, a4_r;
  logic signed [31:0]   py1_r;
  rxp_pkg::sincos_t     tx1_r, tz1_r;
  // Stage 2: x1 and z1.
  logic signed [CO-1:0] x1_2_r, z1_2_r;
  logic signed [31:0]   py2_r;
  rxp_pkg::sincos_t     tx2_r, tz2_r;
  // Stage 3: products for the turn about X.
  logic signed [PW-1:0] b1_r, b2_r, b3_r, b4_r;
  logic signed [CO-1:0] x1_3_r;
  rxp_pkg::sincos_t     tz3_r;
  // Stage 4: y2 and z2.
  logic signed [CO-1:0] x1_4_r, y2_4_r, z2_4_r;
  rxp_pkg::sincos_t     tz4_r;
  // Stage 5: products for the turn about Z.
  logic signed [PW-1:0] c1_r, c2_r, c3_r, c4_r;
  logic signed [CO-1:0] z2_5_r;
  // Stage 6: x3 and y3.
  logic signed [CO-1:0] x3_r, y3_r, z2_6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r   <= in_point.x * trig_y.cos_v;
      a2_r   <= in_point.z * trig_y.sin_v;
      a3_r   <= in_point.z * trig_y.cos_v;
      a4_r   <= in_point.x * trig_y.sin_v;
      py1_r  <= in_point.y;
      tx1_r  <= trig_x;
      tz1_r  <= trig_z;

      x1_2_r <= rxp_pkg::rot_mix(a1_r, a2_r, 1'b0);
      z1_2_r <= rxp_pkg::rot_mix(a3_r, a4_r, 1'b1);
      py2_r  <= py1_r;
      tx2_r  <= tx1_r;
      tz2_r  <= tz1_r;

      b1_r   <= py2_r * tx2_r.cos_v;
      b2_r   <= z1_2_r * tx2_r.sin_v;
      b3_r   <= py2_r * tx2_r.sin_v;
      b4_r   <= z1_2_r * tx2_r.cos_v;
      x1_3_r <= x1_2_r;
      tz3_r  <= tz2_r;

      y2_4_r <= rxp_pkg::rot_mix(b1_r, b2_r, 1'b1);
      z2_4_r <= rxp_pkg::rot_mix(b3_r, b4_r, 1'b0);
      x1_4_r <= x1_3_r;
      tz4_r  <= tz3_r;

      c1_r   <= x1_4_r * tz4_r.cos_v;
      c2_r   <= y2_4_r * tz4_r.sin_v;
      c3_r   <= x1_4_r * tz4_r.sin_v;
      c4_r   <= y2_4_r * tz4_r.cos_v;
      z2_5_r <= z2_4_r;

      x3_r   <= rxp_pkg::rot_mix(c1_r, c2_r, 1'b1);
      y3_r   <= rxp_pkg::rot_mix(c3_r, c4_r, 1'b0);
      z2_6_r <= z2_5_r;
    end
  end

  assign out_valid = vld_r[5];
  assign x3        = x3_r;
  assign y3        = y3_r;
  assign z2        = z2_6_r;

endmodule

[rtl/rxp_divide.sv]
// Perspective scaling: |coord| * focal / denominator by pipelined restoring division,
// one quotient bit per stage, then sign and saturation. Depends on rxp_pkg.
module rxp_divide #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [rxp_pkg::COORD_W-1:0] x3,
  input  logic signed [rxp_pkg::COORD_W-1:0] y3,
  input  logic signed [rxp_pkg::COORD_W-1:0] z2,
  input  logic [15:0]                       focal_length,
  output logic                              out_valid,
  output logic signed [31:0]                screen_x,
  output logic signed [31:0]                screen_y,
  output logic signed [31:0]                depth_z
);

  localparam int CO   = rxp_pkg::COORD_W;
  localparam int FW   = 16 + FRAC_BITS;
  localparam int DW   = ((FW > CO - 1) ? FW : CO - 1) + 1;
  localparam int MAGW = CO - 1;
  localparam int MW   = MAGW + 16;
  localparam int LOWB = 32 - FRAC_BITS;
  localparam int RIW  = MW - LOWB;
  localparam int QB   = 32;
  localparam logic signed [DW:0] MIN_D = (DW+1)'(rxp_pkg::MIN_DENOM) <<< FRAC_BITS;

  logic signed [CO-1:0] coord [0:1];
  assign coord[0] = x3;
  assign coord[1] = y3;

  // Stage 1: magnitudes, clamped focal length, denominator and saturated depth.
  logic [MAGW-1:0]    mag1_r [0:1];
  logic               sgn1_r [0:1];
  logic [15:0]        f1_r;
  logic [DW-1:0]      den1_r;
  logic signed [31:0] dep1_r;
  logic               vld1_r;

  logic [15:0]        f_nxt;
  logic signed [DW:0] d_nxt;
  logic signed [31:0] dep_nxt;

  always_comb begin
    f_nxt = (focal_length < rxp_pkg::MIN_FOCAL) ? rxp_pkg::MIN_FOCAL : focal_length;
    d_nxt = $signed({1'b0, (DW)'({f_nxt, {FRAC_BITS{1'b0}}})}) - (DW+1)'(z2);
    if (d_nxt < MIN_D) begin
      d_nxt = MIN_D;
    end
    if (z2 > CO'(33'sh0_7FFF_FFFF)) begin
      dep_nxt = 32'sh7FFF_FFFF;
    end else if (z2 < -CO'(34'sh0_8000_0000)) begin
      dep_nxt = 32'sh8000_0000;
    end else begin
      dep_nxt = 32'(z2);
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_mag
    logic signed [CO-1:0] ab;
    assign ab = coord[l][CO-1] ? -coord[l] : coord[l];
    always_ff @(posedge clk) begin
      if (en) begin
        mag1_r[l] <= ab[MAGW-1:0];
        sgn1_r[l] <= coord[l][CO-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r   <= f_nxt;
      den1_r <= DW'(d_nxt);
      dep1_r <= dep_nxt;
    end
  end

  // Stage 2: magnitude times focal length; the fraction shift is folded into the bit order.
  logic [MW-1:0]      n2_r [0:1];
  logic               sgn2_r [0:1];
  logic [DW-1:0]      den2_r;
  logic signed [31:0] dep2_r;
  logic               vld2_r;

  for (genvar l = 0; l < 2; l++) begin : g_mul
    always_ff @(posedge clk) begin
      if (en) begin
        n2_r[l]   <= MW'(mag1_r[l]) * MW'(f1_r);
        sgn2_r[l] <= sgn1_r[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den2_r <= den1_r;
      dep2_r <= dep1_r;
    end
  end

  // Division pipeline state, index 0 loaded by the overflow check stage.
  logic [DW-1:0]      rem_r [0:QB][0:1];
  logic [QB-1:0]      q_r   [0:QB][0:1];
  logic [QB-1:0]      lo_r  [0:QB][0:1];
  logic               ovf_r [0:QB][0:1];
  logic               sgn_r [0:QB][0:1];
  logic [DW-1:0]      den_r [0:QB];
  logic signed [31:0] dep_r [0:QB];
  logic               vld_r [0:QB];

  // Stage 3: upper part of the numerator against the denominator flags a quotient of 2^32 or more.
  for (genvar l = 0; l < 2; l++) begin : g_ovf
    logic [RIW-1:0] ri;
    logic           ovf_nxt;
    always_comb begin
      ri      = n2_r[l][MW-1:LOWB];
      ovf_nxt = (DW+1)'(ri) >= (DW+1)'(den2_r);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[0][l] <= ovf_nxt ? '0 : DW'(ri);
        q_r[0][l]   <= '0;
        lo_r[0][l]  <= {n2_r[l][LOWB-1:0], {FRAC_BITS{1'b0}}};
        ovf_r[0][l] <= ovf_nxt;
        sgn_r[0][l] <= sgn2_r[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0] <= den2_r;
      dep_r[0] <= dep2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r   <= 1'b0;
      vld2_r   <= 1'b0;
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld1_r   <= in_valid;
      vld2_r   <= vld1_r;
      vld_r[0] <= vld2_r;
    end
  end

  // One restoring step per stage, most significant quotient bit first.
  for (genvar k = 0; k < QB; k++) begin : g_step
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [DW:0]   t;
      logic          ge;
      logic [DW-1:0] rem_nxt;
      always_comb begin
        t       = {rem_r[k][l], lo_r[k][l][QB-1-k]};
        ge      = t >= {1'b0, den_r[k]};
        rem_nxt = ge ? DW'(t - {1'b0, den_r[k]}) : DW'(t);
      end
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k+1][l] <= rem_nxt;
          q_r[k+1][l]   <= q_r[k][l] | (QB'(ge) << (QB - 1 - k));
          lo_r[k+1][l]  <= lo_r[k][l];
          ovf_r[k+1][l] <= ovf_r[k][l];
          sgn_r[k+1][l] <= sgn_r[k][l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k+1] <= den_r[k];
        dep_r[k+1] <= dep_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end
  end

  // Final stage: apply the sign and saturate to 32 bits.
  logic signed [31:0] res_r [0:1];
  logic signed [31:0] depo_r;
  logic               vldo_r;

  for (genvar l = 0; l < 2; l++) begin : g_sat
    logic [QB-1:0]      q;
    logic signed [31:0] res_nxt;
    always_comb begin
      q = q_r[QB][l];
      if (!sgn_r[QB][l]) begin
        res_nxt = (ovf_r[QB][l] || q[QB-1]) ? 32'sh7FFF_FFFF : $signed(q);
      end else if (ovf_r[QB][l] || (q[QB-1] && (q[QB-2:0] != '0))) begin
        res_nxt = 32'sh8000_0000;
      end else begin
        res_nxt = $signed(-q);
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        res_r[l] <= res_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      depo_r <= dep_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vldo_r <= 1'b0;
    end else if (en) begin
      vldo_r <= vld_r[QB];
    end
  end

  assign out_valid = vldo_r;
  assign screen_x  = res_r[0];
  assign screen_y  = res_r[1];
  assign depth_z   = depo_r;

endmodule

[rtl/rotate_xyz_perspective_project_top.sv]
// Euler rotation (Y, X, Z) and perspective projection of one point per transfer.
// An input transfer passes the 32-stage CORDIC, the 6-stage rotation, the 36-stage divider
// and the output register before out_valid. Throughput: one point per cycle while in_stall
// is low. A one-entry skid behind the output register takes one more result while
// out_stall is high; in_stall follows the skid entry and is high while it is full.
// Reset (rst_n low, synchronous) clears all valid bits and sets focal_length to 400.
module rotate_xyz_perspective_project_top #(
  parameter int FRAC_BITS  = 16,
  parameter int ANGLE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  input  logic [15:0]        in_angle_x,
  input  logic [15:0]        in_angle_y,
  input  logic [15:0]        in_angle_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_screen_x,
  output logic signed [31:0] out_screen_y,
  output logic signed [31:0] out_depth_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_focal_length
);

  localparam int CO = rxp_pkg::COORD_W;

  logic [15:0] focal_r;
  logic        en;

  // Focal length register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_r <= 16'd400;
    end else if (cfg_valid && cfg_ready) begin
      focal_r <= cfg_focal_length;
    end
  end

  // Pipeline advances whenever the skid entry is free.
  logic skid_valid_r;
  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;

  rxp_pkg::point_t  in_pt;
  rxp_pkg::point_t  trig_pt;
  rxp_pkg::sincos_t tr_x, tr_y, tr_z;
  logic             trig_valid;

  assign in_pt.x = in_point_x;
  assign in_pt.y = in_point_y;
  assign in_pt.z = in_point_z;

  rxp_trig #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_trig (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid && !in_stall),
    .angle_x   (in_angle_x),
    .angle_y   (in_angle_y),
    .angle_z   (in_angle_z),
    .in_point  (in_pt),
    .out_valid (trig_valid),
    .out_point (trig_pt),
    .trig_x    (tr_x),
    .trig_y    (tr_y),
    .trig_z    (tr_z)
  );

  logic                 rot_valid;
  logic signed [CO-1:0] x3, y3, z2;

  rxp_rotate u_rotate (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (trig_valid),
    .in_point  (trig_pt),
    .trig_x    (tr_x),
    .trig_y    (tr_y),
    .trig_z    (tr_z),
    .out_valid (rot_valid),
    .x3        (x3),
    .y3        (y3),
    .z2        (z2)
  );

  logic               pipe_valid;
  logic signed [31:0] pipe_sx, pipe_sy, pipe_dz;

  rxp_divide #(
    .FRAC_BITS (FRAC_BITS)
  ) u_divide (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (rot_valid),
    .x3           (x3),
    .y3           (y3),
    .z2           (z2),
    .focal_length (focal_r),
    .out_valid    (pipe_valid),
    .screen_x     (pipe_sx),
    .screen_y     (pipe_sy),
    .depth_z      (pipe_dz)
  );

  // Output register and skid entry.
  logic               out_valid_r;
  logic signed [31:0] out_sx_r, out_sy_r, out_dz_r;
  logic signed [31:0] skid_sx_r, skid_sy_r, skid_dz_r;
  logic               push;
  logic               take;

  assign push = en && pipe_valid;
  assign take = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) begin
        out_sx_r <= skid_sx_r;
        out_sy_r <= skid_sy_r;
        out_dz_r <= skid_dz_r;
      end
    end else if (push) begin
      if (!out_valid_r || take) begin
        out_sx_r <= pipe_sx;
        out_sy_r <= pipe_sy;
        out_dz_r <= pipe_dz;
      end else begin
        skid_sx_r <= pipe_sx;
        skid_sy_r <= pipe_sy;
        skid_dz_r <= pipe_dz;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_screen_x = out_sx_r;
  assign out_screen_y = out_sy_r;
  assign out_depth_z  = out_dz_r;

`ifndef SYNTH
  // The skid entry only fills behind a held output.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid while output register empty");

  // A held skid entry is only released by an output transfer.
  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !take) |=> skid_valid_r)
    else $error("skid entry dropped without an output transfer");

  // A result arriving at a held output goes to the skid entry.
  a_push_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (push && out_valid_r && !take) |=> skid_valid_r)
    else $error("result lost while output was held");
`endif

endmodule
